@@ src/dsched_pkg.sv @@
// Shared types, constants and helpers for the disk request scheduler.
// No dependencies; every other file imports this package.
package dsched_pkg;

  localparam int MAX_REQUESTS_DEF = 32;
  localparam int CYL_W            = 16;
  localparam int MOVE_W           = 22;
  localparam int POLICY_W         = 3;
  localparam int CC_W             = 17;
  localparam int CFG_W            = 17;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYLCOUNT = 2'd2;

  localparam logic [POLICY_W-1:0] POL_FCFS  = 3'd0;
  localparam logic [POLICY_W-1:0] POL_SSTF  = 3'd1;
  localparam logic [POLICY_W-1:0] POL_SCAN  = 3'd2;
  localparam logic [POLICY_W-1:0] POL_CSCAN = 3'd3;
  localparam logic [POLICY_W-1:0] POL_LOOK  = 3'd4;
  localparam logic [POLICY_W-1:0] POL_CLOOK = 3'd5;

  localparam logic [CC_W-1:0] CYLCOUNT_RESET = 17'h10000;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    logic             valid;
    logic             gt;
    logic [CYL_W-1:0] value;
  } cell_link_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INS,
    ST_DUMP,
    ST_PLAN,
    ST_FETCH,
    ST_EMIT,
    ST_SS_FIRST,
    ST_SS_STEP,
    ST_SS_WAIT
  } state_t;

  typedef enum logic [2:0] {
    LEG_FCFS_START,
    LEG_FCFS,
    LEG_DOWN,
    LEG_ZERO,
    LEG_UP,
    LEG_TOP,
    LEG_DNTOP
  } leg_t;

  function automatic logic [CYL_W-1:0] absdiff(input logic [CYL_W-1:0] a,
                                               input logic [CYL_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ src/dsched_ifs.sv @@
// Valid/ready channel interfaces for request input and visit output.
// Depends on dsched_pkg for field widths.
interface dsched_in_if;
  import dsched_pkg::*;
  logic             valid;
  logic             ready;
  logic [CYL_W-1:0] cylinder;
  logic             batch_end;
  modport source (output valid, cylinder, batch_end, input ready);
  modport sink   (input valid, cylinder, batch_end, output ready);
endinterface

interface dsched_out_if;
  import dsched_pkg::*;
  logic              valid;
  logic              ready;
  logic [CYL_W-1:0]  visit_position;
  logic [MOVE_W-1:0] total_movement;
  logic              final_item;
  modport source (output valid, visit_position, total_movement, final_item, input ready);
  modport sink   (input valid, visit_position, total_movement, final_item, output ready);
endinterface

@@ src/dsched_cell.sv @@
// One slot of the sorted insertion chain: holds a cylinder and a valid bit.
// Depends on dsched_pkg (cell_op_t, cell_link_t).
module dsched_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dsched_pkg::cell_op_t         op,
  input  logic [dsched_pkg::CYL_W-1:0] ins_val,
  input  dsched_pkg::cell_link_t       left,
  input  dsched_pkg::cell_link_t       right,
  output dsched_pkg::cell_link_t       self
);
  import dsched_pkg::*;

  logic [CYL_W-1:0] value_r, value_nxt;
  logic             valid_r, valid_nxt;
  logic             gt;

  assign gt = valid_r && (value_r > ins_val);
  assign self = '{valid: valid_r, gt: gt, value: value_r};

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    case (op)
      CELL_INSERT: begin
        // entries above the new value move one slot right
        if (left.gt) begin
          value_nxt = left.value;
          valid_nxt = 1'b1;
        end else if (gt || (!valid_r && left.valid)) begin
          value_nxt = ins_val;
          valid_nxt = 1'b1;
        end
      end
      CELL_SHIFT: begin
        value_nxt = right.value;
        valid_nxt = right.valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    value_r <= value_nxt;
  end

endmodule

@@ src/disk_request_scheduler_top.sv @@
// Disk request scheduler top level: insertion chain, stores and visit sequencer.
// Depends on dsched_pkg, dsched_ifs (channel interfaces) and dsched_cell.
//
// Usage: requests arrive on in_ch, one transaction per cylinder; the transaction
// with batch_end set closes the batch. Requests beyond MAX_REQUESTS are dropped.
// Each request enters the sorted chain in the cycle it is accepted, so loading
// runs at one request per cycle. After the closing request the start cylinder
// is inserted and the chain is unloaded into the sorted store. Visits then
// leave on out_ch, those from the request or sorted store by its registered
// read; the last visit has final_item set and carries the total head
// movement. in_ch stays not ready until the last visit has entered the output
// register. A stalled out_ch holds the sequencer; one visit waits in the output
// register while the next is prepared. Reset clears the chain, the count and
// the output valid, and sets policy FCFS, start 0, 65536 cylinders.
// Configuration through cfg_we/cfg_index/cfg_wdata is meant for the next batch:
// the user must write it between batches; the block itself does not enforce it.
module disk_request_scheduler_top #(
  parameter int MAX_REQUESTS = dsched_pkg::MAX_REQUESTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  dsched_in_if.sink                        in_ch,
  dsched_out_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [dsched_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsched_pkg::CFG_W-1:0]     cfg_wdata
);
  import dsched_pkg::*;

  localparam int NSLOTS = MAX_REQUESTS + 1;
  localparam int AW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int IW     = $clog2(MAX_REQUESTS + 2);

  // configuration
  logic [POLICY_W-1:0] policy_r;
  logic [CYL_W-1:0]    start_r;
  logic [CC_W-1:0]     cylcnt_r;
  logic [CC_W-1:0]     cc_m1;
  logic [CYL_W-1:0]    top_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FCFS;
      start_r  <= '0;
      cylcnt_r <= CYLCOUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLICY:   policy_r <= cfg_wdata[POLICY_W-1:0];
        CFG_START:    start_r  <= cfg_wdata[CYL_W-1:0];
        CFG_CYLCOUNT: cylcnt_r <= cfg_wdata[CC_W-1:0];
        default: ;
      endcase
    end
  end

  assign cc_m1   = cylcnt_r - 1'b1;
  assign top_pos = (cylcnt_r == '0) ? '0 :
                   (cylcnt_r > CYLCOUNT_RESET) ? {CYL_W{1'b1}} : cc_m1[CYL_W-1:0];

  // sorted insertion chain
  cell_link_t       link [NSLOTS];
  cell_op_t         cell_op;
  logic [CYL_W-1:0] ins_val;

  for (genvar i = 0; i < NSLOTS; i++) begin : g_cell
    cell_link_t left_l, right_l;
    if (i == 0) begin : g_first
      assign left_l = '{valid: 1'b1, gt: 1'b0, value: '0};
    end else begin : g_mid
      assign left_l = link[i-1];
    end
    if (i == NSLOTS - 1) begin : g_last
      assign right_l = '0;
    end else begin : g_inner
      assign right_l = link[i+1];
    end
    dsched_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (cell_op),
      .ins_val (ins_val),
      .left    (left_l),
      .right   (right_l),
      .self    (link[i])
    );
  end

  // sequencer state
  state_t            state_r, state_nxt;
  leg_t              leg_r, leg_nxt;
  logic [IW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     p_r, p_nxt;
  logic              found_r, found_nxt;
  logic [CYL_W-1:0]  cur_r, cur_nxt;
  logic [MOVE_W-1:0] sum_r, sum_nxt;
  logic [IW-1:0]     lo_r, lo_nxt;
  logic              lo_ok_r, lo_ok_nxt;
  logic [IW-1:0]     hi_r, hi_nxt;
  logic [IW-1:0]     steps_r, steps_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CYL_W-1:0]  out_pos_r, out_pos_nxt;
  logic [MOVE_W-1:0] out_mov_r, out_mov_nxt;
  logic              out_fin_r, out_fin_nxt;

  // stores
  logic [CYL_W-1:0] req_mem [NSLOTS];
  logic [CYL_W-1:0] smem    [NSLOTS];
  logic [CYL_W-1:0] req_rd_r, sa_rd_r, sb_rd_r;
  logic             req_we, s_we;
  logic [IW-1:0]    req_wa;
  logic [IW-1:0]    sa_addr;

  assign sa_addr = (state_r == ST_SS_FIRST || state_r == ST_SS_STEP ||
                    state_r == ST_SS_WAIT) ? lo_r : idx_r;

  always_ff @(posedge clk) begin
    if (req_we) req_mem[req_wa[AW-1:0]] <= in_ch.cylinder;
    if (s_we)   smem[idx_r[AW-1:0]]     <= link[0].value;
    req_rd_r <= req_mem[idx_r[AW-1:0]];
    sa_rd_r  <= smem[sa_addr[AW-1:0]];
    sb_rd_r  <= smem[hi_r[AW-1:0]];
  end

  logic              out_free;
  logic              accept;
  logic [CYL_W-1:0]  v;
  logic [CYL_W-1:0]  delta;
  logic              last;
  logic              p_lt_n;
  logic              hi_ok;
  logic              choose_lo;
  logic [IW-1:0]     p_plus1;

  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ch.ready;
  assign p_lt_n   = p_r < count_r;
  assign p_plus1  = p_r + 1'b1;
  assign hi_ok    = hi_r <= count_r;

  always_comb begin
    state_nxt     = state_r;
    leg_nxt       = leg_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    found_nxt     = found_r;
    cur_nxt       = cur_r;
    sum_nxt       = sum_r;
    lo_nxt        = lo_r;
    lo_ok_nxt     = lo_ok_r;
    hi_nxt        = hi_r;
    steps_nxt     = steps_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pos_nxt   = out_pos_r;
    out_mov_nxt   = out_mov_r;
    out_fin_nxt   = out_fin_r;
    cell_op       = CELL_HOLD;
    ins_val       = in_ch.cylinder;
    in_ch.ready   = 1'b0;
    req_we        = 1'b0;
    req_wa        = count_r + 1'b1;
    s_we          = 1'b0;
    v             = '0;
    delta         = '0;
    last          = 1'b0;
    choose_lo     = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        in_ch.ready = 1'b1;
        if (accept) begin
          if (count_r < IW'(MAX_REQUESTS)) begin
            cell_op   = CELL_INSERT;
            req_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (in_ch.batch_end) state_nxt = ST_INS;
        end
      end

      ST_INS: begin
        cell_op   = CELL_INSERT;
        ins_val   = start_r;
        idx_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = ST_DUMP;
      end

      ST_DUMP: begin
        // chain drains from cell 0 into the sorted store
        cell_op = CELL_SHIFT;
        s_we    = 1'b1;
        if (!found_r && link[0].value == start_r) begin
          p_nxt     = idx_r;
          found_nxt = 1'b1;
        end
        if (idx_r == count_r) state_nxt = ST_PLAN;
        else                  idx_nxt   = idx_r + 1'b1;
      end

      ST_PLAN: begin
        cur_nxt = start_r;
        sum_nxt = '0;
        case (policy_r)
          POL_SSTF: begin
            lo_ok_nxt = (p_r != '0);
            lo_nxt    = p_r - 1'b1;
            hi_nxt    = p_plus1;
            steps_nxt = '0;
            state_nxt = ST_SS_FIRST;
          end
          POL_SCAN, POL_CSCAN, POL_LOOK, POL_CLOOK: begin
            leg_nxt   = LEG_DOWN;
            idx_nxt   = p_r;
            state_nxt = ST_FETCH;
          end
          default: begin
            leg_nxt   = LEG_FCFS_START;
            idx_nxt   = '0;
            state_nxt = ST_FETCH;
          end
        endcase
      end

      ST_FETCH: state_nxt = ST_EMIT;

      ST_EMIT: begin
        case (leg_r)
          LEG_FCFS_START: v = start_r;
          LEG_FCFS:       v = req_rd_r;
          LEG_ZERO:       v = '0;
          LEG_TOP:        v = top_pos;
          default:        v = sa_rd_r;
        endcase
        delta = absdiff(cur_r, v);
        if (leg_r == LEG_TOP) begin
          delta = '0;
        end else if (leg_r == LEG_DNTOP) begin
          // return jumps are free; C-SCAN counts its leg as top to lowest visit
          if (policy_r == POL_CSCAN)
            delta = (idx_r == p_plus1) ? absdiff(top_pos, v) : '0;
          else if (idx_r == count_r)
            delta = '0;
        end

        case (leg_r)
          LEG_FCFS_START: begin
            last    = (count_r == '0);
            leg_nxt = LEG_FCFS;
            idx_nxt = IW'(1);
          end
          LEG_FCFS, LEG_UP: begin
            last    = (idx_r == count_r);
            idx_nxt = idx_r + 1'b1;
          end
          LEG_DOWN: begin
            if (idx_r != '0) begin
              idx_nxt = idx_r - 1'b1;
            end else if (policy_r == POL_SCAN || policy_r == POL_CSCAN) begin
              leg_nxt = LEG_ZERO;
            end else if (!p_lt_n) begin
              last = 1'b1;
            end else if (policy_r == POL_LOOK) begin
              leg_nxt = LEG_UP;
              idx_nxt = p_plus1;
            end else begin
              leg_nxt = LEG_DNTOP;
              idx_nxt = count_r;
            end
          end
          LEG_ZERO: begin
            if (!p_lt_n) begin
              last = 1'b1;
            end else if (policy_r == POL_SCAN) begin
              leg_nxt = LEG_UP;
              idx_nxt = p_plus1;
            end else begin
              leg_nxt = LEG_TOP;
            end
          end
          LEG_TOP: begin
            leg_nxt = LEG_DNTOP;
            idx_nxt = count_r;
          end
          default: begin
            last    = (idx_r == p_plus1);
            idx_nxt = idx_r - 1'b1;
          end
        endcase

        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = v;
          sum_nxt       = sum_r + MOVE_W'(delta);
          out_mov_nxt   = last ? sum_nxt : '0;
          out_fin_nxt   = last;
          cur_nxt       = v;
          if (last) begin
            count_nxt = '0;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_FETCH;
          end
        end else begin
          leg_nxt = leg_r;
          idx_nxt = idx_r;
        end
      end

      ST_SS_FIRST: begin
        if (out_free) begin
          last          = (count_r == '0);
          out_valid_nxt = 1'b1;
          out_pos_nxt   = start_r;
          out_mov_nxt   = '0;
          out_fin_nxt   = last;
          if (last) begin
            count_nxt = '0;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_SS_STEP;
          end
        end
      end

      ST_SS_STEP: begin
        // ties go upward
        if (lo_ok_r && hi_ok)
          choose_lo = absdiff(sa_rd_r, cur_r) < absdiff(sb_rd_r, cur_r);
        else
          choose_lo = !hi_ok;
        v     = choose_lo ? sa_rd_r : sb_rd_r;
        delta = absdiff(cur_r, v);
        last  = (steps_r + 1'b1) == count_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = v;
          sum_nxt       = sum_r + MOVE_W'(delta);
          out_mov_nxt   = last ? sum_nxt : '0;
          out_fin_nxt   = last;
          cur_nxt       = v;
          steps_nxt     = steps_r + 1'b1;
          if (choose_lo) begin
            lo_ok_nxt = (lo_r != '0);
            lo_nxt    = lo_r - 1'b1;
          end else begin
            hi_nxt = hi_r + 1'b1;
          end
          if (last) begin
            count_nxt = '0;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_SS_WAIT;
          end
        end
      end

      ST_SS_WAIT: state_nxt = ST_SS_STEP;

      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    leg_r     <= leg_nxt;
    idx_r     <= idx_nxt;
    p_r       <= p_nxt;
    cur_r     <= cur_nxt;
    sum_r     <= sum_nxt;
    lo_r      <= lo_nxt;
    lo_ok_r   <= lo_ok_nxt;
    hi_r      <= hi_nxt;
    steps_r   <= steps_nxt;
    out_pos_r <= out_pos_nxt;
    out_mov_r <= out_mov_nxt;
    out_fin_r <= out_fin_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.visit_position = out_pos_r;
  assign out_ch.total_movement = out_mov_r;
  assign out_ch.final_item     = out_fin_r;

endmodule

@@ dv/dsched_checker.sv @@
// Scoreboard for the disk request scheduler: mirrors configuration writes, collects
// request transactions, predicts each batch's visit sequence and checks out_ch.
// Depends on dsched_pkg and the channel interfaces in dsched_ifs.
module dsched_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  dsched_in_if                             in_ch,
  dsched_out_if                            out_ch,
  input  logic                             cfg_we,
  input  logic [dsched_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsched_pkg::CFG_W-1:0]     cfg_wdata,
  output int                               errors,
  output int                               pending,
  output int                               batches,
  output int                               visits
);
  import dsched_pkg::*;

  localparam int MAX_REQ = MAX_REQUESTS_DEF;

  typedef struct {
    logic [CYL_W-1:0]  visit;
    logic [MOVE_W-1:0] movement;
    logic              last;
  } visit_t;

  logic [POLICY_W-1:0] policy_q;
  logic [CYL_W-1:0]    start_q;
  logic [CC_W-1:0]     cylcount_q;
  logic [CYL_W-1:0]    held_reqs[$];
  visit_t              expected_visits[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch @%0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic push_visit(input logic [CYL_W-1:0] pos);
    visit_t v;
    v.visit    = pos;
    v.movement = '0;
    v.last     = 1'b0;
    expected_visits = {expected_visits, v};
  endtask

  // Works out the whole visit order and head travel of the batch just closed.
  task automatic schedule_batch();
    logic [CYL_W-1:0] order[$];
    logic [CYL_W-1:0] srt[$];
    logic [31:0]      travel;
    logic [31:0]      top;
    logic [31:0]      cur_pos;
    int               n, p, cur, lo, hi, nxt;
    order   = {start_q, held_reqs};
    srt     = order;
    srt.sort();
    n       = held_reqs.size();
    travel  = 0;
    p = 0;
    for (int i = n; i >= 0; i--)
      if (srt[i] == start_q) p = i;
    if (cylcount_q == 0) top = 0;
    else if (cylcount_q > 17'h10000) top = 32'hFFFF;
    else top = cylcount_q - 1;
    case (policy_q)
      POL_SSTF: begin
        cur = p; lo = p - 1; hi = p + 1;
        push_visit(srt[cur]);
        for (int t = 0; t < n; t++) begin
          if (lo >= 0 && hi <= n) begin
            if (absdiff(srt[lo], srt[cur]) < absdiff(srt[hi], srt[cur])) nxt = lo--;
            else nxt = hi++;
          end else if (hi <= n) nxt = hi++;
          else nxt = lo--;
          travel += absdiff(srt[nxt], srt[cur]);
          cur = nxt;
          push_visit(srt[cur]);
        end
      end
      POL_SCAN, POL_CSCAN, POL_LOOK, POL_CLOOK: begin
        for (int i = p; i >= 0; i--) push_visit(srt[i]);
        if (policy_q == POL_SCAN || policy_q == POL_CSCAN) begin
          push_visit('0);
          travel += srt[p];
        end else travel += srt[p] - srt[0];
        if (p < n) begin
          if (policy_q == POL_SCAN || policy_q == POL_LOOK) begin
            for (int i = p + 1; i <= n; i++) push_visit(srt[i]);
            travel += (policy_q == POL_SCAN) ? 32'(srt[n]) : 32'(srt[n]) - srt[0];
          end else begin
            if (policy_q == POL_CSCAN) push_visit(top[CYL_W-1:0]);
            for (int i = n; i > p; i--) push_visit(srt[i]);
            if (policy_q == POL_CSCAN)
              travel += (top > srt[p+1]) ? top - srt[p+1] : srt[p+1] - top;
            else travel += srt[n] - srt[p+1];
          end
        end
      end
      default: begin
        // codes 6 and 7 fall back to first-come order
        cur_pos = start_q;
        for (int i = 0; i <= n; i++) begin
          travel += (cur_pos > order[i]) ? cur_pos - order[i] : order[i] - cur_pos;
          cur_pos = order[i];
          push_visit(order[i]);
        end
      end
    endcase
    expected_visits[$].movement = travel[MOVE_W-1:0];
    expected_visits[$].last     = 1'b1;
    held_reqs = {};
    batches++;
  endtask

  initial begin
    errors = 0; pending = 0; batches = 0; visits = 0;
  end

  always @(posedge clk) begin
    visit_t e;
    if (!rst_n) begin
      policy_q   = POL_FCFS;
      start_q    = '0;
      cylcount_q = CYLCOUNT_RESET;
      held_reqs  = {};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY:   policy_q   = cfg_wdata[POLICY_W-1:0];
          CFG_START:    start_q    = cfg_wdata[CYL_W-1:0];
          CFG_CYLCOUNT: cylcount_q = cfg_wdata[CC_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        visits++;
        if (expected_visits.size() == 0) begin
          report("unexpected visit", out_ch.visit_position, 0);
        end else begin
          e = expected_visits.pop_front();
          if (out_ch.visit_position != e.visit)
            report("visit_position", out_ch.visit_position, e.visit);
          if (out_ch.total_movement != e.movement)
            report("total_movement", out_ch.total_movement, e.movement);
          if (out_ch.final_item != e.last)
            report("final_item", out_ch.final_item, e.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (held_reqs.size() < MAX_REQ) held_reqs = {held_reqs, in_ch.cylinder};
        if (in_ch.batch_end) schedule_batch();
      end
    end
    pending = expected_visits.size();
  end
endmodule

@@ dv/disk_request_scheduler_top_tb.sv @@
// Top of the disk request scheduler testbench: clock, reset, request and config
// stimulus, receiver stalls and the verdict. Depends on dsched_pkg, dsched_ifs,
// dsched_checker and the scheduler RTL.
module disk_request_scheduler_top_tb;
  import dsched_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 420;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   errors, pending, batches, visits;
  int                   cycles;
  int                   sent;
  int                   burst_left;
  int                   stall_mode;

  dsched_in_if  in_ch();
  dsched_out_if out_ch();

  disk_request_scheduler_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  dsched_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending), .batches(batches), .visits(visits)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: full speed, random stalls, or long stalls, in a randomly chosen mode
  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // the enable is dropped after each write so it falls between writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [2:0] pol, input logic [15:0] st,
                            input logic [16:0] cc);
    write_reg(CFG_POLICY, CFG_W'(pol));
    write_reg(CFG_START, CFG_W'(st));
    write_reg(CFG_CYLCOUNT, cc);
  endtask

  // one request transaction, sender idles in random bursts
  task automatic send_request(input logic [15:0] cyl, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.cylinder  <= cyl;
    in_ch.batch_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  // sends a batch, then waits out the schedule so config can change safely
  task automatic run_batch(input logic [15:0] cyls[$]);
    foreach (cyls[i]) send_request(cyls[i], i == cyls.size() - 1);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_cylinder(input logic [15:0] near);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return near + 16'($urandom_range(0, 40)) - 16'd20;
      3: return near;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] pick_cylcount();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'h10000;
      3: return 17'($urandom_range(17'h10001, 17'h1FFFF));
      default: return 17'($urandom_range(2, 17'hFFFF));
    endcase
  endfunction

  initial begin
    logic [15:0] batch[$];
    logic [15:0] st;
    int          len;
    cycles = 0; sent = 0; burst_left = 0; stall_mode = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.cylinder = '0; in_ch.batch_end = 1'b0;
    out_ch.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // head at the top: nothing above the start for the sweeping policies
    for (int pol = 0; pol <= 5; pol++) begin
      set_config(3'(pol), 16'hFFFF, 17'h10000);
      run_batch('{16'h0000, 16'h8000});
    end
    // one cylinder, request beyond the top
    for (int pol = 2; pol <= 5; pol++) begin
      set_config(3'(pol), 16'h0000, 17'd1);
      run_batch('{16'hFFFF, 16'h0000});
    end
    // undefined policy codes
    set_config(3'd6, 16'h1234, 17'h1FFFF);
    run_batch('{16'hAAAA, 16'h5555});
    set_config(3'd7, 16'h5555, 17'd0);
    run_batch('{16'h5555, 16'hAAAA});

    while (sent < RAND_ITEMS + 24) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
      st  = 16'($urandom);
      batch = {};
      for (int i = 0; i < len; i++) batch = {batch, pick_cylinder(st)};
      if ($urandom_range(0, 2) == 0) st = batch[$urandom_range(0, len - 1)];
      if ($urandom_range(0, 3) != 0) write_reg(CFG_POLICY, CFG_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_START, CFG_W'(st));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_CYLCOUNT, pick_cylcount());
      run_batch(batch);
    end

    repeat (20) @(posedge clk);
    $display("covered %0d requests in %0d batches, %0d visits checked", sent, batches, visits);
    $display("all six policies plus fallback codes, full store, empty upward side");
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
